FILE: sv/serial_command_keyword_parser_top_macros.svh
// Assertion macros used by the serial command keyword parser RTL.
`ifndef SERIAL_COMMAND_KEYWORD_PARSER_TOP_MACROS_SVH
`define SERIAL_COMMAND_KEYWORD_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SCP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scp assertion failed");
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scp assertion failed");
`else
`define SCP_ASSERT(label, clk, rst_n, prop)
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/scp_pkg.sv
// Package: command codes, character constants and stage types for the parser.
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

    typedef enum logic [3:0] {
        CMD_NONE = 4'd0,
        CMD_RUN  = 4'd1,
        CMD_RY   = 4'd2,
        CMD_RG   = 4'd3,
        CMD_YR   = 4'd4,
        CMD_GR   = 4'd5,
        CMD_SET  = 4'd6,
        CMD_MAN  = 4'd7,
        CMD_DATA = 4'd8
    } cmd_t;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_Y    = 8'h79;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } stage_t;

endpackage

`default_nettype wire

FILE: sv/scp_if.sv
// Channel interfaces: received byte stream and parsed command stream.
`timescale 1ns / 1ps
`default_nettype none

interface scp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scp_cmd_if;
    logic          valid;
    logic          ready;
    scp_pkg::cmd_t command;
    logic          payload_byte;

    modport source (output valid, output command, output payload_byte, input ready);
    modport sink   (input valid, input command, input payload_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/serial_command_keyword_parser_top.sv
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle; the input register and the result register
// each step whenever the stage after them is free. A waiting result holds the
// result register; rx takes one more byte into the input register, then stalls.
// Reset: asynchronous, active low; parser returns to idle and both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_keyword_parser_top (
    input  wire logic clk,
    input  wire logic rst_n,
    scp_byte_if.sink  rx,
    scp_cmd_if.source tx
);
    import scp_pkg::*;

    stage_t item;
    logic   take;

    scp_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .item  (item),
        .take  (take)
    );

    scp_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .tx    (tx)
    );

endmodule

`default_nettype wire

FILE: sv/scp_in_stage.sv
// Input register stage: captures one received byte per transaction.
`timescale 1ns / 1ps
`default_nettype none

module scp_in_stage (
    input  wire logic      clk,
    input  wire logic      rst_n,
    scp_byte_if.sink       rx,
    output scp_pkg::stage_t item,
    input  wire logic      take
);
    import scp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign rx.ready   = !valid_reg || take;
    assign accept     = rx.valid && rx.ready;
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/scp_fsm.sv
// Keyword automaton with its result register.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_command_keyword_parser_top_macros.svh"

module scp_fsm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scp_pkg::stage_t item,
    output logic                 take,
    scp_cmd_if.source            tx
);
    import scp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,
        ST_MARK = 5'd1,
        ST_R    = 5'd2,
        ST_RU   = 5'd3,
        ST_RUN  = 5'd4,
        ST_RY   = 5'd5,
        ST_RG   = 5'd6,
        ST_Y    = 5'd7,
        ST_YR   = 5'd8,
        ST_G    = 5'd9,
        ST_GR   = 5'd10,
        ST_S    = 5'd11,
        ST_SE   = 5'd12,
        ST_SET  = 5'd13,
        ST_M    = 5'd14,
        ST_MA   = 5'd15,
        ST_MAN  = 5'd16,
        ST_STAR = 5'd17
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic       pay_reg;
    logic       pay_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] c;
    logic       is_hash;

    assign c       = item.data;
    assign is_hash = (c == CH_HASH);
    assign take    = item.valid && (!valid_reg || tx.ready);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = CMD_NONE;
        pay_next   = 1'b0;
        if (c == CH_BANG)
        begin
            state_next = ST_MARK;
        end
        else
        begin
            case (state_reg)
                ST_MARK:
                begin
                    if (c == CH_R)         state_next = ST_R;
                    else if (c == CH_Y)    state_next = ST_Y;
                    else if (c == CH_G)    state_next = ST_G;
                    else if (c == CH_S)    state_next = ST_S;
                    else if (c == CH_M)    state_next = ST_M;
                    else if (c == CH_STAR) state_next = ST_STAR;
                    else                   state_next = ST_IDLE;
                end
                ST_R:
                begin
                    if (c == CH_G)      state_next = ST_RG;
                    else if (c == CH_U) state_next = ST_RU;
                    else if (c == CH_Y) state_next = ST_RY;
                    else                state_next = ST_IDLE;
                end
                ST_RU: state_next = (c == CH_N) ? ST_RUN : ST_IDLE;
                ST_Y:  state_next = (c == CH_R) ? ST_YR  : ST_IDLE;
                ST_G:  state_next = (c == CH_R) ? ST_GR  : ST_IDLE;
                ST_S:  state_next = (c == CH_E) ? ST_SE  : ST_IDLE;
                ST_SE: state_next = (c == CH_T) ? ST_SET : ST_IDLE;
                ST_M:  state_next = (c == CH_A) ? ST_MA  : ST_IDLE;
                ST_MA: state_next = (c == CH_N) ? ST_MAN : ST_IDLE;
                ST_RUN:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_RUN : CMD_NONE;
                end
                ST_RY:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_RY : CMD_NONE;
                end
                ST_RG:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_RG : CMD_NONE;
                end
                ST_YR:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_YR : CMD_NONE;
                end
                ST_GR:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_GR : CMD_NONE;
                end
                ST_SET:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_SET : CMD_NONE;
                end
                ST_MAN:
                begin
                    state_next = ST_IDLE;
                    cmd_next   = is_hash ? CMD_MAN : CMD_NONE;
                end
                ST_STAR:
                begin
                    if (is_hash)
                    begin
                        state_next = ST_IDLE;
                        cmd_next   = CMD_DATA;
                    end
                    else
                    begin
                        pay_next = 1'b1;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    assign valid_next = take ? 1'b1 : (tx.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            cmd_reg   <= CMD_NONE;
            pay_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                state_reg <= state_next;
                cmd_reg   <= cmd_next;
                pay_reg   <= pay_next;
            end
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.command      = cmd_reg;
    assign tx.payload_byte = pay_reg;

    // a command and a payload mark never come together
    `SCP_ASSERT(a_cmd_pay_excl, clk, rst_n, !(valid_reg && cmd_reg != CMD_NONE && pay_reg))
    `SCP_ASSERT_NEXT(a_cmd_to_idle, clk, rst_n, take && cmd_next != CMD_NONE, state_reg == ST_IDLE)
    `SCP_ASSERT_NEXT(a_pay_in_frame, clk, rst_n, take && pay_next, state_reg == ST_STAR)
    `SCP_ASSERT_NEXT(a_bang_restart, clk, rst_n, take && c == CH_BANG, state_reg == ST_MARK)
    `SCP_ASSERT_NEXT(a_hold_state, clk, rst_n, !take, $stable(state_reg))

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the keyword parser: directed, random and backpressure runs.
`timescale 1ns / 1ps

module tb;
    import scp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [4:0] {
        PS_IDLE, PS_MARK, PS_R, PS_RU, PS_RUN, PS_RY, PS_RG, PS_Y, PS_YR,
        PS_G, PS_GR, PS_S, PS_SE, PS_SET, PS_M, PS_MA, PS_MAN, PS_STAR
    } parse_state_t;

    typedef struct {
        cmd_t command;
        logic payload_byte;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rx_hold = 1'b0;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int payload_bytes_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int command_hits[9];

    parse_state_t  kw_state = PS_IDLE;
    parse_result_t pending_results[$];

    string keywords[7] = '{"run", "ry", "rg", "yr", "gr", "set", "man"};

    scp_byte_if rx_if();
    scp_cmd_if  tx_if();

    serial_command_keyword_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if.sink),
        .tx    (tx_if.source)
    );

    always #1 clk = ~clk;

    function automatic parse_state_t match_next(logic [7:0] c, logic [7:0] want,
                                                parse_state_t nxt);
        return (c == want) ? nxt : PS_IDLE;
    endfunction

    function automatic parse_result_t parse_keyword_byte(logic [7:0] c);
        parse_result_t r;
        r.command = CMD_NONE;
        r.payload_byte = 1'b0;
        if (c == CH_BANG)
        begin
            kw_state = PS_MARK;
        end
        else
        begin
            case (kw_state)
                PS_MARK:
                begin
                    case (c)
                        CH_R:    kw_state = PS_R;
                        CH_Y:    kw_state = PS_Y;
                        CH_G:    kw_state = PS_G;
                        CH_S:    kw_state = PS_S;
                        CH_M:    kw_state = PS_M;
                        CH_STAR: kw_state = PS_STAR;
                        default: kw_state = PS_IDLE;
                    endcase
                end
                PS_R:
                begin
                    case (c)
                        CH_G:    kw_state = PS_RG;
                        CH_U:    kw_state = PS_RU;
                        CH_Y:    kw_state = PS_RY;
                        default: kw_state = PS_IDLE;
                    endcase
                end
                PS_RU: kw_state = match_next(c, CH_N, PS_RUN);
                PS_Y:  kw_state = match_next(c, CH_R, PS_YR);
                PS_G:  kw_state = match_next(c, CH_R, PS_GR);
                PS_S:  kw_state = match_next(c, CH_E, PS_SE);
                PS_SE: kw_state = match_next(c, CH_T, PS_SET);
                PS_M:  kw_state = match_next(c, CH_A, PS_MA);
                PS_MA: kw_state = match_next(c, CH_N, PS_MAN);
                PS_RUN, PS_RY, PS_RG, PS_YR, PS_GR, PS_SET, PS_MAN:
                begin
                    if (c == CH_HASH)
                    begin
                        case (kw_state)
                            PS_RUN:  r.command = CMD_RUN;
                            PS_RY:   r.command = CMD_RY;
                            PS_RG:   r.command = CMD_RG;
                            PS_YR:   r.command = CMD_YR;
                            PS_GR:   r.command = CMD_GR;
                            PS_SET:  r.command = CMD_SET;
                            default: r.command = CMD_MAN;
                        endcase
                    end
                    kw_state = PS_IDLE;
                end
                PS_STAR:
                begin
                    if (c == CH_HASH)
                    begin
                        r.command = CMD_DATA;
                        kw_state = PS_IDLE;
                    end
                    else
                    begin
                        r.payload_byte = 1'b1;
                    end
                end
                default: kw_state = PS_IDLE;
            endcase
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        forever
        begin
            @(negedge clk);
            if (rx_if.ready)
            begin
                pending_results.push_back(parse_keyword_byte(b));
                bytes_sent++;
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] random_body_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (b == CH_BANG || b == CH_HASH);
        return b;
    endfunction

    task automatic send_random_sequence();
        int kind;
        int idx;
        int len;
        kind = $urandom_range(99);
        idx = $urandom_range(6);
        if (kind < 45)
        begin
            send_byte(CH_BANG);
            send_text(keywords[idx]);
            send_byte(CH_HASH);
        end
        else if (kind < 65)
        begin
            send_byte(CH_BANG);
            send_byte(CH_STAR);
            len = $urandom_range(6);
            for (int i = 0; i < len; i++)
            begin
                send_byte(random_body_byte());
            end
            send_byte(($urandom_range(9) == 0) ? CH_BANG : CH_HASH);
        end
        else if (kind < 85)
        begin
            send_byte(CH_BANG);
            len = $urandom_range(keywords[idx].len());
            for (int i = 0; i < len; i++)
            begin
                send_byte(keywords[idx][i]);
            end
            send_byte(8'($urandom_range(255)));
        end
        else
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_random(int count, int src_pct, int snk_pct);
        int target;
        target = bytes_sent + count;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        while (bytes_sent < target)
        begin
            send_random_sequence();
        end
    endtask

    task automatic test_directed_keywords();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("!run#!ry#!rg#!yr#!gr#");
        send_text("!s!set#");
        send_text("!man#");
        send_text("!*");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("*#");
        send_text("!rx#");
    endtask

    task automatic test_random_no_idle();
        run_random(400, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random(400, 71, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random(400, 0, 71);
    endtask

    task automatic test_random_both_idle();
        run_random(400, 26, 26);
    endtask

    task automatic test_long_hold_off();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        run_random(250, 0, 0);
    endtask

    always @(posedge clk)
    begin
        tx_if.ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= snk_stall_pct);
    end

    always @(negedge clk)
    begin
        parse_result_t exp_r;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: command %0d payload_byte %0b",
                       tx_if.command, tx_if.payload_byte);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (tx_if.command !== exp_r.command)
                begin
                    $error("command mismatch: expected %0d, got %0d",
                           exp_r.command, tx_if.command);
                    fail_count++;
                end
                if (tx_if.payload_byte !== exp_r.payload_byte)
                begin
                    $error("payload_byte mismatch: expected %0b, got %0b",
                           exp_r.payload_byte, tx_if.payload_byte);
                    fail_count++;
                end
                if (exp_r.command <= CMD_DATA)
                begin
                    command_hits[exp_r.command]++;
                end
                if (exp_r.payload_byte)
                begin
                    payload_bytes_seen++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[serial_command_keyword_parser_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        tx_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_keywords();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_long_hold_off();

        rx_if.valid <= 1'b0;
        snk_stall_pct = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d results, %0d payload bytes",
                 bytes_sent, results_checked, payload_bytes_seen);
        $display("commands run/ry/rg/yr/gr/set/man/data: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 command_hits[CMD_RUN], command_hits[CMD_RY], command_hits[CMD_RG],
                 command_hits[CMD_YR], command_hits[CMD_GR], command_hits[CMD_SET],
                 command_hits[CMD_MAN], command_hits[CMD_DATA]);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("[serial_command_keyword_parser_top] OK");
        end
        else
        begin
            $display("[serial_command_keyword_parser_top] ERROR");
        end
        $finish;
    end
endmodule

FILE: serial_command_keyword_parser_top.f
+incdir+sv
sv/scp_pkg.sv
sv/scp_if.sv
sv/scp_in_stage.sv
sv/scp_fsm.sv
sv/serial_command_keyword_parser_top.sv
tb/sv/tb.sv
